>>> hw/rtl/grmd_pkg.sv
// Shared types, constants and the sine table for the grid ray march distance unit.
`timescale 1ns / 1ps
package grmd_pkg;

   localparam int MARCH_STEPS_DEF = 512;
   localparam int GRID_SIZE_DEF   = 8;
   localparam int CELL_PIXELS_DEF = 64;

   localparam int FOV_HALF     = 64;
   localparam int ANGLE_W      = 9;
   localparam int COLUMN_W     = 7;
   localparam int DIST_W       = 10;
   localparam int HALF_W       = 15;
   localparam int MAP_W        = 64;
   localparam int POS_IN_W     = 9;
   localparam int TRIG_W       = 15;
   localparam int FRAC_W       = 14;
   localparam int CSR_ADDR_W   = 2;
   localparam int DIST_MAX     = 1023;
   localparam int HALF_SCALE   = 16384;

   localparam logic [MAP_W-1:0]    WALL_MAP_RST = '0;
   localparam logic [POS_IN_W-1:0] PLAYER_X_RST = 9'd270;
   localparam logic [POS_IN_W-1:0] PLAYER_Y_RST = 9'd275;
   localparam logic [ANGLE_W-1:0]  HEADING_RST  = 9'd128;

   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WALL_MAP = 2'd0,
      CSR_PLAYER_X = 2'd1,
      CSR_PLAYER_Y = 2'd2,
      CSR_HEADING  = 2'd3
   } csr_index_type;

   typedef logic [TRIG_W-1:0] sine_lut_type [129];

   typedef struct packed {
      logic              neg;
      logic [TRIG_W-1:0] mag;
   } trig_type;

   typedef struct packed {
      logic load;
      logic step;
      logic sq_a;
      logic sq_b;
      logic root_step;
      logic div_init;
      logic div_step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic last_step;
      logic root_last;
      logic div_last;
      logic out_free;
   } status_type;

   function automatic logic [63:0] taylor_term(input logic [63:0] v, input int i);
      logic [63:0] r;
      case (i)
         0: r = v / 64'd156;
         1: r = v / 64'd110;
         2: r = v / 64'd72;
         3: r = v / 64'd42;
         4: r = v / 64'd20;
         default: r = v / 64'd6;
      endcase
      return r;
   endfunction

   function automatic sine_lut_type build_sine();
      sine_lut_type lut;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      for (int k = 0; k <= 128; k++) begin
         x  = (64'(k) * PI_Q30) >> 8;
         x2 = (x * x) >> 30;
         t  = ONE_Q30;
         for (int i = 0; i < 6; i++) begin
            t = ONE_Q30 - taylor_term((x2 * t) >> 30, i);
         end
         t = (x * t) >> 30;
         lut[k] = TRIG_W'((t + 64'd32768) >> 16);
      end
      return lut;
   endfunction

   localparam sine_lut_type SINE_LUT = build_sine();

   function automatic trig_type sine_lookup(input logic [ANGLE_W-1:0] a);
      trig_type r;
      logic [7:0] idx;
      if (a <= 9'd128) begin
         idx = a[7:0];
         r.neg = 1'b0;
      end else if (a <= 9'd256) begin
         idx = 8'(9'd256 - a);
         r.neg = 1'b0;
      end else if (a <= 9'd384) begin
         idx = 8'(a - 9'd256);
         r.neg = 1'b1;
      end else begin
         idx = 8'(10'd512 - 10'(a));
         r.neg = 1'b1;
      end
      r.mag = SINE_LUT[idx];
      return r;
   endfunction

endpackage

>>> hw/rtl/grmd_ctrl.sv
// Sequencer for march, square, root and divide phases of one ray.
`timescale 1ns / 1ps
module grmd_ctrl
   import grmd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_MARCH = 8'b00000010,
      S_SQA   = 8'b00000100,
      S_SQB   = 8'b00001000,
      S_ROOT  = 8'b00010000,
      S_DINIT = 8'b00100000,
      S_DIV   = 8'b01000000,
      S_FIN   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MARCH;
            end
         end
         S_MARCH: begin
            if (status.hit) begin
               state_in = S_SQA;
            end else if (status.last_step) begin
               state_in = S_FIN;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_SQA: begin
            cmd.sq_a = 1'b1;
            state_in = S_SQB;
         end
         S_SQB: begin
            cmd.sq_b = 1'b1;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) state_in = S_DINIT;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_FIN;
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_load_march: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_MARCH)
      else $error("load did not start march");
   a_hit_square: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARCH && status.hit) |=> state_ff == S_SQA)
      else $error("hit did not start squaring");
   a_publish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> status.out_free)
      else $error("publish into a full output stage");
`endif

endmodule

>>> hw/rtl/grmd_dp.sv
// Datapath: settings, ray march accumulators, wall test, root and divide units, output stage.
`timescale 1ns / 1ps
module grmd_dp
   import grmd_pkg::*;
#(
   parameter int MARCH_STEPS = MARCH_STEPS_DEF,
   parameter int GRID_SIZE   = GRID_SIZE_DEF,
   parameter int CELL_PIXELS = CELL_PIXELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [MAP_W-1:0]      csr_wdata,
   input  logic [COLUMN_W-1:0]   column,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [COLUMN_W-1:0]   column_out,
   output logic [DIST_W-1:0]     distance,
   output logic [HALF_W-1:0]     half_height,
   output logic                  missed,
   input  cmd_type               cmd,
   output status_type            status
);

   localparam int N_W    = $clog2(MARCH_STEPS + 1);
   localparam int ACC_W  = TRIG_W + N_W;
   localparam int ADJ_W  = ACC_W - FRAC_W;
   localparam int POS_W  = ((ADJ_W > 12) ? ADJ_W : 12) + 2;
   localparam int SQ_W   = 2 * ADJ_W + 2;
   localparam int CELL_W = 3;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = $clog2(HALF_W);

   logic [MAP_W-1:0]    wall_map_ff;
   logic [POS_IN_W-1:0] player_x_ff, player_y_ff;
   logic [ANGLE_W-1:0]  heading_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_map_ff <= WALL_MAP_RST;
         player_x_ff <= PLAYER_X_RST;
         player_y_ff <= PLAYER_Y_RST;
         heading_ff  <= HEADING_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_WALL_MAP: wall_map_ff <= csr_wdata;
            CSR_PLAYER_X: player_x_ff <= csr_wdata[POS_IN_W-1:0];
            CSR_PLAYER_Y: player_y_ff <= csr_wdata[POS_IN_W-1:0];
            CSR_HEADING:  heading_ff  <= csr_wdata[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   logic [COLUMN_W-1:0] column_ff;
   logic                c_neg_ff, s_neg_ff;
   logic [TRIG_W-1:0]   c_mag_ff, s_mag_ff;
   logic [ACC_W-1:0]    acc_c_ff, acc_s_ff;
   logic [N_W-1:0]      step_ff;
   logic [ANGLE_W-1:0]  angle;
   trig_type            sin_v, cos_v;

   assign angle = heading_ff - ANGLE_W'(FOV_HALF) + ANGLE_W'(column);
   assign sin_v = sine_lookup(angle);
   assign cos_v = sine_lookup(angle + ANGLE_W'(128));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         column_ff <= column;
         c_neg_ff  <= cos_v.neg;
         s_neg_ff  <= sin_v.neg;
         c_mag_ff  <= cos_v.mag;
         s_mag_ff  <= sin_v.mag;
         acc_c_ff  <= ACC_W'(cos_v.mag);
         acc_s_ff  <= ACC_W'(sin_v.mag);
         step_ff   <= N_W'(1);
      end else if (cmd.step) begin
         acc_c_ff <= acc_c_ff + ACC_W'(c_mag_ff);
         acc_s_ff <= acc_s_ff + ACC_W'(s_mag_ff);
         step_ff  <= step_ff + N_W'(1);
      end
   end

   logic [ADJ_W-1:0] adj_m, opp_m;
   logic [POS_W-1:0] pos_x, pos_y;
   logic [CELL_W-1:0] cx, cy;
   logic [IDX_W-1:0]  cell_idx;
   logic              outside;

   assign adj_m = acc_c_ff[ACC_W-1:FRAC_W];
   assign opp_m = acc_s_ff[ACC_W-1:FRAC_W];
   assign pos_x = c_neg_ff ? POS_W'(player_x_ff) + POS_W'(adj_m)
                           : POS_W'(player_x_ff) - POS_W'(adj_m);
   assign pos_y = s_neg_ff ? POS_W'(player_y_ff) + POS_W'(opp_m)
                           : POS_W'(player_y_ff) - POS_W'(opp_m);

   always_comb begin
      cx = '0;
      cy = '0;
      for (int k = 1; k < GRID_SIZE; k++) begin
         if (pos_x >= POS_W'(k * CELL_PIXELS)) cx = cx + CELL_W'(1);
         if (pos_y >= POS_W'(k * CELL_PIXELS)) cy = cy + CELL_W'(1);
      end
   end

   assign outside  = pos_x[POS_W-1] || pos_y[POS_W-1]
                  || pos_x >= POS_W'(GRID_SIZE * CELL_PIXELS)
                  || pos_y >= POS_W'(GRID_SIZE * CELL_PIXELS);
   assign cell_idx = IDX_W'(cy) * IDX_W'(GRID_SIZE) + IDX_W'(cx);

   assign status.hit       = outside || wall_map_ff[cell_idx];
   assign status.last_step = (step_ff == N_W'(MARCH_STEPS));

   logic [ADJ_W-1:0]   mul_op;
   logic [2*ADJ_W-1:0] prod;
   logic [SQ_W-1:0]    sq_ff;
   logic [SQ_W-1:0]    root_v_ff, root_r_ff, root_bit_ff, root_sum;

   assign mul_op = cmd.sq_a ? adj_m : opp_m;
   assign prod   = mul_op * mul_op;
   assign root_sum = root_r_ff + root_bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.sq_a) sq_ff <= SQ_W'(prod);
      if (cmd.sq_b) begin
         root_v_ff   <= sq_ff + SQ_W'(prod);
         root_r_ff   <= '0;
         root_bit_ff <= SQ_W'(1) << (SQ_W - 2);
      end else if (cmd.root_step) begin
         if (root_v_ff >= root_sum) begin
            root_v_ff <= root_v_ff - root_sum;
            root_r_ff <= (root_r_ff >> 1) + root_bit_ff;
         end else begin
            root_r_ff <= root_r_ff >> 1;
         end
         root_bit_ff <= root_bit_ff >> 2;
      end
   end

   assign status.root_last = (root_bit_ff == SQ_W'(1));

   logic [DIST_W-1:0] dist_ff, dist_val, div_d_ff;
   logic [DIST_W-1:0] rem_ff;
   logic [DIST_W:0]   trial;
   logic [HALF_W-1:0] quo_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              missed_ff;
   logic [HALF_W-1:0] dividend;

   assign dividend = HALF_W'(HALF_SCALE);
   assign dist_val = (root_r_ff > SQ_W'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                   : root_r_ff[DIST_W-1:0];
   assign trial    = {rem_ff, dividend[cnt_ff]};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         missed_ff <= 1'b1;
      end else if (cmd.div_init) begin
         missed_ff <= 1'b0;
         dist_ff   <= dist_val;
         div_d_ff  <= (dist_val == '0) ? DIST_W'(1) : dist_val;
         rem_ff    <= '0;
         quo_ff    <= '0;
         cnt_ff    <= CNT_W'(HALF_W - 1);
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, div_d_ff}) begin
            rem_ff         <= DIST_W'(trial - {1'b0, div_d_ff});
            quo_ff[cnt_ff] <= 1'b1;
         end else begin
            rem_ff <= trial[DIST_W-1:0];
         end
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign status.div_last = (cnt_ff == '0);

   logic rsp_valid_ff;
   logic [COLUMN_W-1:0] out_col_ff;
   logic [DIST_W-1:0]   out_dist_ff;
   logic [HALF_W-1:0]   out_half_ff;
   logic                out_miss_ff;

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_col_ff  <= column_ff;
         out_dist_ff <= missed_ff ? '0 : dist_ff;
         out_half_ff <= missed_ff ? '0 : quo_ff;
         out_miss_ff <= missed_ff;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign column_out  = out_col_ff;
   assign distance    = out_dist_ff;
   assign half_height = out_half_ff;
   assign missed      = out_miss_ff;

endmodule

>>> hw/rtl/grid_ray_march_distance_unit.sv
// Top level of the grid ray march distance unit.
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tdata: column
//  rsp     | out | rsp_tvalid/tready   | tdata: column_out, distance, half_height; tuser: missed
//  csr     | in  | csr_we              | csr_addr, csr_wdata
// One ray marches up to MARCH_STEPS steps, one per cycle, and ends there on a miss; on a hit
// it then passes through the square, root and divide phases before its beat is published.
// Synchronous active-high reset restores the default settings and empties the output stage.
// A finished beat waits in the output register; the next ray is taken meanwhile.
`timescale 1ns / 1ps
module grid_ray_march_distance_unit
   import grmd_pkg::*;
#(
   parameter int MARCH_STEPS = MARCH_STEPS_DEF,
   parameter int GRID_SIZE   = GRID_SIZE_DEF,
   parameter int CELL_PIXELS = CELL_PIXELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // column[6:0], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,  // column_out[6:0], distance[16:7], half_height[31:17]
   output logic                  rsp_tuser,  // missed
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [MAP_W-1:0]      csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic [COLUMN_W-1:0] column_out;
   logic [DIST_W-1:0]   distance;
   logic [HALF_W-1:0]   half_height;

   grmd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   grmd_dp #(
      .MARCH_STEPS (MARCH_STEPS),
      .GRID_SIZE   (GRID_SIZE),
      .CELL_PIXELS (CELL_PIXELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .column      (req_tdata[COLUMN_W-1:0]),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .column_out  (column_out),
      .distance    (distance),
      .half_height (half_height),
      .missed      (rsp_tuser),
      .cmd         (cmd),
      .status      (status)
   );

   assign rsp_tdata = {half_height, distance, column_out};

`ifndef SYNTHESIS
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (distance == '0 && half_height == '0))
      else $error("miss beat carries a distance");
   a_hit_height: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> half_height != '0)
      else $error("hit beat with zero height");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second ray taken while marching");
`endif

endmodule
